[src/dfng_pkg.sv]
// dfng_pkg: shared widths, register indexes and reset values
// for the density filter neighbor generator; no dependencies
package dfng_pkg;

  localparam int COORD_W  = 10;
  localparam int SIZE_W   = 11;
  localparam int FIX_W    = 16;
  localparam int IDX_W    = 30;
  localparam int WGT_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_REACH_DEF = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_WGT = 3'd7;

  localparam logic [SIZE_W-1:0] SIZE_RST    = 11'd1;
  localparam logic [FIX_W-1:0]  SPACING_RST = 16'd256;
  localparam logic [FIX_W-1:0]  RADIUS_RST  = 16'd384;
  localparam logic [FIX_W-1:0]  FIXED_RST   = 16'd0;

endpackage

[src/density_filter_neighbor_generator_core.sv]
// density_filter_neighbor_generator_core: emits sparse filter entries of one element
// depends on dfng_pkg
// sequence: serial setup multiplies, then a walk over the offsets; each kept offset with
// distance weighting also takes a serial root and divide (32 root steps, 16 divide steps)
// rst is synchronous; registers return to size 1, spacing 1.0, radius 1.5, weight off
// one element is accepted only while the sequencer is idle
module density_filter_neighbor_generator_core #(
  parameter int MAX_REACH = dfng_pkg::MAX_REACH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // elem_x, elem_y, elem_z, 2 zero bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // row_index, col_index, weight, 4 zero bits
  output logic        m_tlast
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_OFS   = 3'd2;
  localparam logic [2:0] ST_SQRT  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;

  // setup multiplies, in issue order
  localparam logic [2:0] OP_R2   = 3'd0;
  localparam logic [2:0] OP_SQX  = 3'd1;
  localparam logic [2:0] OP_SQY  = 3'd2;
  localparam logic [2:0] OP_SQZ  = 3'd3;
  localparam logic [2:0] OP_SXSY = 3'd4;
  localparam logic [2:0] OP_ZY   = 3'd5;
  localparam logic [2:0] OP_LAST = 3'd6;

  logic [10:0] size_x, size_y, size_z;
  logic [15:0] spacing_x, spacing_y, spacing_z, radius, fixed_weight;

  logic [2:0]  state;
  logic [2:0]  op;
  logic [4:0]  cnt;
  logic [9:0]  ex, ey, ez;
  logic [31:0] ma, macc;
  logic [15:0] mb;
  logic [31:0] r2, qx, qy, qz;
  logic [29:0] sxsy, row;
  logic [1:0]  ci, cj, ck;
  logic [29:0] cur_col;
  logic [23:0] cur_wgt;
  logic [63:0] sv;
  logic [31:0] srt;
  logic [35:0] srem;
  logic [16:0] drem;
  logic [15:0] dv, dq;
  logic        pend_valid;
  logic [29:0] pend_col;
  logic [23:0] pend_wgt;
  logic [29:0] out_row, out_col;
  logic [23:0] out_wgt;
  logic        out_last;

  // reach per axis
  logic rx, ry, rz;
  assign rx = (MAX_REACH != 0) && ((spacing_x == '0) || (radius >= spacing_x));
  assign ry = (MAX_REACH != 0) && ((spacing_y == '0) || (radius >= spacing_y));
  assign rz = (MAX_REACH != 0) && ((spacing_z == '0) || (radius >= spacing_z));

  logic [1:0] ilo, ihi, jlo, jhi, klo, khi;
  assign ilo = rx ? 2'd0 : 2'd1;
  assign ihi = rx ? 2'd2 : 2'd1;
  assign jlo = ry ? 2'd0 : 2'd1;
  assign jhi = ry ? 2'd2 : 2'd1;
  assign klo = rz ? 2'd0 : 2'd1;
  assign khi = rz ? 2'd2 : 2'd1;

  // serial multiplier final step and next operand selection
  logic [31:0] prod;
  logic [31:0] ld_a;
  logic [15:0] ld_b;
  logic [2:0]  ld_op;
  assign prod = macc + (mb[0] ? ma : 32'd0);

  always_comb begin
    ld_op = (state == ST_IDLE) ? OP_R2 : op + 3'd1;
    case (ld_op)
      OP_R2:   begin ld_a = {16'd0, radius}; ld_b = radius; end
      OP_SQX:  begin ld_a = {16'd0, spacing_x}; ld_b = spacing_x; end
      OP_SQY:  begin ld_a = {16'd0, spacing_y}; ld_b = spacing_y; end
      OP_SQZ:  begin ld_a = {16'd0, spacing_z}; ld_b = spacing_z; end
      OP_SXSY: begin ld_a = {21'd0, size_x}; ld_b = {5'd0, size_y}; end
      OP_ZY:   begin ld_a = {22'd0, ez}; ld_b = {5'd0, size_y}; end
      OP_LAST: begin ld_a = prod + {22'd0, ey}; ld_b = {5'd0, size_x}; end
      default: begin ld_a = '0; ld_b = '0; end
    endcase
  end

  // offset evaluation
  logic [33:0] d2;
  logic        in_x, in_y, in_z, keep;
  logic [29:0] off_x, off_y, off_z, col;
  logic [10:0] ex1;
  logic        ofs_done;
  logic [1:0]  ci_next, cj_next, ck_next;

  always_comb begin
    d2 = {2'd0, (ci != 2'd1) ? qx : 32'd0} + {2'd0, (cj != 2'd1) ? qy : 32'd0}
       + {2'd0, (ck != 2'd1) ? qz : 32'd0};
    ex1 = {1'b0, ex};
    case (ci)
      2'd0:    in_x = (ex != '0) && ((ex1 - 11'd1) < size_x);
      2'd2:    in_x = (ex1 + 11'd1) < size_x;
      default: in_x = ex1 < size_x;
    endcase
    case (cj)
      2'd0:    in_y = (ey != '0) && (({1'b0, ey} - 11'd1) < size_y);
      2'd2:    in_y = ({1'b0, ey} + 11'd1) < size_y;
      default: in_y = {1'b0, ey} < size_y;
    endcase
    case (ck)
      2'd0:    in_z = (ez != '0) && (({1'b0, ez} - 11'd1) < size_z);
      2'd2:    in_z = ({1'b0, ez} + 11'd1) < size_z;
      default: in_z = {1'b0, ez} < size_z;
    endcase
    keep = (d2 < {2'd0, r2}) && in_x && in_y && in_z;
    case (ci)
      2'd0:    off_x = '1;
      2'd2:    off_x = 30'd1;
      default: off_x = '0;
    endcase
    case (cj)
      2'd0:    off_y = 30'd0 - {19'd0, size_x};
      2'd2:    off_y = {19'd0, size_x};
      default: off_y = '0;
    endcase
    case (ck)
      2'd0:    off_z = 30'd0 - sxsy;
      2'd2:    off_z = sxsy;
      default: off_z = '0;
    endcase
    col = row + off_x + off_y + off_z;
    ofs_done = (ci == ihi) && (cj == jhi) && (ck == khi);
    ci_next = (ci != ihi) ? ci + 2'd1 : ilo;
    cj_next = (ci != ihi) ? cj : ((cj != jhi) ? cj + 2'd1 : jlo);
    ck_next = ((ci != ihi) || (cj != jhi)) ? ck : ck + 2'd1;
  end

  // root and divide steps
  logic [35:0] rem_sh, trial;
  logic [16:0] dsh;
  assign rem_sh = {srem[33:0], sv[63:62]};
  assign trial  = {2'd0, srt, 2'b01};
  assign dsh    = {drem[15:0], dv[15]};

  logic out_free;
  logic out_load;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = ((state == ST_PUSH) || (state == ST_FLUSH)) && pend_valid && out_free;
  assign s_tready = (state == ST_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= dfng_pkg::SIZE_RST;
      size_y <= dfng_pkg::SIZE_RST;
      size_z <= dfng_pkg::SIZE_RST;
      spacing_x <= dfng_pkg::SPACING_RST;
      spacing_y <= dfng_pkg::SPACING_RST;
      spacing_z <= dfng_pkg::SPACING_RST;
      radius <= dfng_pkg::RADIUS_RST;
      fixed_weight <= dfng_pkg::FIXED_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        dfng_pkg::REG_SIZE_X:    size_x <= cfg_data[10:0];
        dfng_pkg::REG_SIZE_Y:    size_y <= cfg_data[10:0];
        dfng_pkg::REG_SIZE_Z:    size_z <= cfg_data[10:0];
        dfng_pkg::REG_SPACING_X: spacing_x <= cfg_data;
        dfng_pkg::REG_SPACING_Y: spacing_y <= cfg_data;
        dfng_pkg::REG_SPACING_Z: spacing_z <= cfg_data;
        dfng_pkg::REG_RADIUS:    radius <= cfg_data;
        dfng_pkg::REG_FIXED_WGT: fixed_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ex <= s_tdata[9:0];
            ey <= s_tdata[19:10];
            ez <= s_tdata[29:20];
            op <= ld_op;
            ma <= ld_a;
            mb <= ld_b;
            macc <= '0;
            cnt <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt == 5'd15) begin
            case (op)
              OP_R2:   r2 <= prod;
              OP_SQX:  qx <= prod;
              OP_SQY:  qy <= prod;
              OP_SQZ:  qz <= prod;
              OP_SXSY: sxsy <= prod[29:0];
              default: row <= prod[29:0] + {20'd0, ex};
            endcase
            if (op == OP_LAST) begin
              ci <= ilo;
              cj <= jlo;
              ck <= klo;
              state <= ST_OFS;
            end else begin
              op <= ld_op;
              ma <= ld_a;
              mb <= ld_b;
              macc <= '0;
              cnt <= '0;
            end
          end else begin
            macc <= prod;
            ma <= {ma[30:0], 1'b0};
            mb <= {1'b0, mb[15:1]};
            cnt <= cnt + 5'd1;
          end
        end
        ST_OFS: begin
          if (keep) begin
            cur_col <= col;
            if (fixed_weight != '0) begin
              cur_wgt <= {fixed_weight, 8'd0};
              state <= ST_PUSH;
            end else begin
              sv <= {d2[31:0], 32'd0};
              srt <= '0;
              srem <= '0;
              cnt <= '0;
              state <= ST_SQRT;
            end
          end else if (ofs_done) begin
            state <= ST_FLUSH;
          end else begin
            ci <= ci_next;
            cj <= cj_next;
            ck <= ck_next;
          end
        end
        ST_SQRT: begin
          sv <= {sv[61:0], 2'b00};
          if (rem_sh >= trial) begin
            srem <= rem_sh - trial;
            srt <= {srt[30:0], 1'b1};
          end else begin
            srem <= rem_sh;
            srt <= {srt[30:0], 1'b0};
          end
          // counter wraps to zero after the last root step
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == 5'd0) begin
            drem <= {1'b0, srt[31:16]};
            dv <= srt[15:0];
            dq <= '0;
            cnt <= 5'd1;
          end else begin
            dv <= {dv[14:0], 1'b0};
            if (dsh >= {1'b0, radius}) begin
              drem <= dsh - {1'b0, radius};
              dq <= {dq[14:0], 1'b1};
            end else begin
              drem <= dsh;
              dq <= {dq[14:0], 1'b0};
            end
            cnt <= cnt + 5'd1;
            if (cnt == 5'd16) begin
              cur_wgt <= 24'h010000 - {8'd0, dq[14:0], (dsh >= {1'b0, radius})};
              state <= ST_PUSH;
            end
          end
        end
        ST_PUSH: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_row <= row;
              out_col <= pend_col;
              out_wgt <= pend_wgt;
              out_last <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_col <= cur_col;
            pend_wgt <= cur_wgt;
            if (ofs_done) begin
              state <= ST_FLUSH;
            end else begin
              ci <= ci_next;
              cj <= cj_next;
              ck <= ck_next;
              state <= ST_OFS;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_row <= row;
            out_col <= pend_col;
            out_wgt <= pend_wgt;
            out_last <= 1'b1;
            pend_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'd0, out_wgt, out_col, out_row};
  assign m_tlast = out_last;

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid) else $error("pending entry left in idle");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE)) else $error("ready outside idle");
  a_wgt_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && fixed_weight == '0 && state != ST_IDLE)
      |-> (out_wgt != '0 && out_wgt <= 24'h010000)) else $error("weight out of range");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH && pend_valid && !out_free) |=> (state == ST_PUSH))
    else $error("entry pushed over a held result");

endmodule

[dv/density_filter_neighbor_generator_core_test.sv]
// density_filter_neighbor_generator_core_test: drives element coordinates and checks every
// emitted filter entry against an in-bench predictor of neighbor walk and linear-hat weight
// depends on dfng_pkg and density_filter_neighbor_generator_core
`timescale 1ns / 100ps

module density_filter_neighbor_generator_core_test;

  typedef struct {
    logic [dfng_pkg::IDX_W-1:0] row_index;
    logic [dfng_pkg::IDX_W-1:0] col_index;
    logic [dfng_pkg::WGT_W-1:0] weight;
    logic                       last_entry;
  } entry_t;

  class entry_scoreboard;
    entry_t      pending[$];
    logic [10:0] sx, sy, sz;
    logic [15:0] spx, spy, spz, rad, fixw;
    int          errors;
    int          n_elems;
    int          n_entries;

    function void reset_regs();
      sx = dfng_pkg::SIZE_RST; sy = dfng_pkg::SIZE_RST; sz = dfng_pkg::SIZE_RST;
      spx = dfng_pkg::SPACING_RST; spy = dfng_pkg::SPACING_RST; spz = dfng_pkg::SPACING_RST;
      rad = dfng_pkg::RADIUS_RST; fixw = dfng_pkg::FIXED_RST;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        dfng_pkg::REG_SIZE_X:    sx = val[10:0];
        dfng_pkg::REG_SIZE_Y:    sy = val[10:0];
        dfng_pkg::REG_SIZE_Z:    sz = val[10:0];
        dfng_pkg::REG_SPACING_X: spx = val;
        dfng_pkg::REG_SPACING_Y: spy = val;
        dfng_pkg::REG_SPACING_Z: spz = val;
        dfng_pkg::REG_RADIUS:    rad = val;
        dfng_pkg::REG_FIXED_WGT: fixw = val;
        default: ;
      endcase
    endfunction

    function int reach_of(logic [15:0] sp);
      longint unsigned r;
      if (sp == 0) return dfng_pkg::MAX_REACH_DEF;
      r = longint'(rad) / longint'(sp);
      return (r > dfng_pkg::MAX_REACH_DEF) ? dfng_pkg::MAX_REACH_DEF : int'(r);
    endfunction

    function logic [dfng_pkg::IDX_W-1:0] flat(longint unsigned x, longint unsigned y,
                                              longint unsigned z);
      longint unsigned v;
      v = x + y * sx + z * sx * sy;
      return v[dfng_pkg::IDX_W-1:0];
    endfunction

    function logic [dfng_pkg::WGT_W-1:0] hat_weight(longint unsigned d2);
      longint unsigned q, c, p, target;
      q = 0;
      target = d2 << 32;
      for (int b = 15; b >= 0; b--) begin
        c = q | (64'd1 << b);
        p = c * rad;
        if (p * p <= target) q = c;
      end
      return dfng_pkg::WGT_W'(65536 - q);
    endfunction

    function void note_element(logic [9:0] ex, logic [9:0] ey, logic [9:0] ez);
      int rx, ry, rz, n, first;
      longint nx, ny, nz;
      longint unsigned ax, ay, az, d2, r2;
      logic [dfng_pkg::IDX_W-1:0] row;
      entry_t e;
      rx = reach_of(spx); ry = reach_of(spy); rz = reach_of(spz);
      r2 = longint'(rad) * rad;
      row = flat(ex, ey, ez);
      n = 0;
      first = pending.size();
      n_elems++;
      for (int k = -rz; k <= rz; k++)
        for (int j = -ry; j <= ry; j++)
          for (int i = -rx; i <= rx; i++) begin
            ax = longint'(i < 0 ? -i : i) * spx;
            ay = longint'(j < 0 ? -j : j) * spy;
            az = longint'(k < 0 ? -k : k) * spz;
            d2 = ax * ax + ay * ay + az * az;
            nx = longint'(ex) + i; ny = longint'(ey) + j; nz = longint'(ez) + k;
            if (d2 < r2 && nx >= 0 && nx < sx && ny >= 0 && ny < sy && nz >= 0 && nz < sz
                && n < 27) begin
              e.row_index = row;
              e.col_index = flat(nx, ny, nz);
              e.weight = (fixw != 0) ? {fixw, 8'd0} : hat_weight(d2);
              e.last_entry = 1'b0;
              pending.push_back(e);
              n++;
            end
          end
      if (n > 0) pending[first + n - 1].last_entry = 1'b1;
    endfunction

    function void check_entry(logic [87:0] d, logic last);
      entry_t e;
      n_entries++;
      if (pending.size() == 0) begin
        $error("unexpected entry row=%0d col=%0d", d[29:0], d[59:30]);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[29:0] !== e.row_index) begin
        $error("row_index exp %0d got %0d", e.row_index, d[29:0]); errors++;
      end
      if (d[59:30] !== e.col_index) begin
        $error("col_index exp %0d got %0d", e.col_index, d[59:30]); errors++;
      end
      if (d[83:60] !== e.weight) begin
        $error("weight exp %0d got %0d", e.weight, d[83:60]); errors++;
      end
      if (last !== e.last_entry) begin
        $error("last_entry exp %0d got %0d", e.last_entry, last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wen = 0;
  logic [2:0]  cfg_index = dfng_pkg::REG_SIZE_X;
  logic [15:0] cfg_data = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [87:0] m_tdata;
  logic        m_tlast;

  entry_scoreboard sb;
  bit          idle_on = 1;

  density_filter_neighbor_generator_core u_top (.*);

  always #4 clk = ~clk;

  // receiver with random stall bursts
  initial begin
    int gap;
    @(posedge clk);
    while (1) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 14);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) sb.check_entry(m_tdata, m_tlast);

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_wen <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1600) @(posedge clk);
  endtask

  task automatic send_element(logic [9:0] ex, logic [9:0] ey, logic [9:0] ez);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, ez, ey, ex};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_element(ex, ey, ez);
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(logic [10:0] x, logic [10:0] y, logic [10:0] z, logic [15:0] spx,
                         logic [15:0] spy, logic [15:0] spz, logic [15:0] r, logic [15:0] f);
    write_cfg(dfng_pkg::REG_SIZE_X, {5'd0, x}); write_cfg(dfng_pkg::REG_SIZE_Y, {5'd0, y});
    write_cfg(dfng_pkg::REG_SIZE_Z, {5'd0, z});
    write_cfg(dfng_pkg::REG_SPACING_X, spx); write_cfg(dfng_pkg::REG_SPACING_Y, spy);
    write_cfg(dfng_pkg::REG_SPACING_Z, spz); write_cfg(dfng_pkg::REG_RADIUS, r);
    write_cfg(dfng_pkg::REG_FIXED_WGT, f);
  endtask

  function automatic logic [9:0] coord(logic [10:0] n);
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    return 10'($urandom_range(0, (n == 0) ? 0 : n - 1));
  endfunction

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, corners and interior
    send_element(0, 0, 0);
    drain();
    set_all(4, 4, 4, 256, 256, 256, 512, 0);
    send_element(0, 0, 0); send_element(3, 3, 3); send_element(1, 2, 1);
    send_element(1023, 1023, 1023);
    drain();
    // fixed weight, max fields, zero spacing, zero radius, zero size, huge grid
    set_all(1024, 1024, 1024, 65535, 1, 0, 65535, 65535);
    send_element(0, 1023, 512); send_element(1023, 0, 1023);
    drain();
    set_all(1024, 1024, 1024, 1, 1, 1, 1, 1);
    send_element(512, 512, 512);
    drain();
    set_all(8, 8, 1, 100, 200, 300, 0, 0);
    send_element(2, 2, 0);
    drain();
    set_all(0, 8, 8, 256, 256, 256, 600, 0);
    send_element(2, 2, 2);
    drain();
    set_all(1024, 1024, 1024, 256, 256, 256, 450, 0);
    send_element(1023, 1023, 1023); send_element(700, 300, 5);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      logic [10:0] x, y, z;
      x = 11'($urandom_range(1, 12)); y = 11'($urandom_range(1, 12));
      z = ($urandom_range(0, 2) == 0) ? 11'd1 : 11'($urandom_range(1, 12));
      if (ph == 3) begin x = 11'd1024; y = 11'd1024; z = 11'd1024; end
      set_all(x, y, z, 16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
              16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
              16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
              16'($urandom_range(1, 65535) >> $urandom_range(0, 15)),
              ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'd0);
      if (ph == 9) idle_on = 0;
      for (int i = 0; i < 50; i++) begin
        send_element(coord(x), coord(y), coord(z));
        if (i == 25) while (sb.pending.size() != 0) @(posedge clk);
      end
      drain();
    end

    $display("covered %0d elements, %0d filter entries, across many grid/radius settings",
             sb.n_elems, sb.n_entries);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
src/dfng_pkg.sv
src/density_filter_neighbor_generator_core.sv
dv/density_filter_neighbor_generator_core_test.sv
